// File: rtl/ckvt_pkg.sv
// Shared types and constants for the context key/value table.
// Holds the command and status codes and the channel payload structs.
// No dependencies.
package ckvt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int DISP_W = 8;
  localparam int RES_W  = 29;
  localparam int CTX_W  = 32;
  localparam int DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_SAVE   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [DISP_W-1:0]   display_handle;
    logic [RES_W-1:0]    resource_id;
    logic [CTX_W-1:0]    context_id;
    logic [DATA_W-1:0]   write_data;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   found_data;
  } out_t;

endpackage

// File: rtl/context_key_value_table.sv
// Context key/value table: associative store keyed by display, resource and context.
// Scans the slots one per cycle with a single key comparator.
// Depends on ckvt_pkg.
//
//   channel  | ports                         | direction
//   ---------+-------------------------------+----------
//   request  | in_valid, in_stall, in_data   | in
//   result   | out_valid, out_stall, out_data| out
//
// Every command takes the transfer, passes each slot in turn through the shared key
// comparator, then commits the result.
// in_stall is high from the transfer until the result enters the output register.
// The result waits in the output register while out_stall is high; the next
// request is accepted meanwhile, and its commit waits for the register to free.
// Reset clears every slot valid bit and the control state at once.
module context_key_value_table
  import ckvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [DISP_W-1:0]        slot_disp_r [TABLE_ENTRIES];
  logic [RES_W-1:0]         slot_res_r  [TABLE_ENTRIES];
  logic [CTX_W-1:0]         slot_ctx_r  [TABLE_ENTRIES];
  logic [DATA_W-1:0]        slot_data_r [TABLE_ENTRIES];

  in_t               req_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [DATA_W-1:0] hit_data_r, hit_data_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;

  logic  out_valid_r, out_valid_nxt;
  out_t  out_data_r, out_data_nxt;

  logic  in_xfer, commit, key_match, last_slot;
  logic  wr_key, wr_data;
  logic [IDX_W-1:0] wr_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign commit    = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign last_slot = (idx_r == IDX_W'(TABLE_ENTRIES - 1));

  // shared comparator: one slot per cycle
  assign key_match = valid_r[idx_r]
                  && (slot_disp_r[idx_r] == req_r.display_handle)
                  && (slot_res_r[idx_r]  == req_r.resource_id)
                  && (slot_ctx_r[idx_r]  == req_r.context_id);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_data_nxt   = hit_data_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_key         = 1'b0;
    wr_data        = 1'b0;
    wr_idx         = hit_idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_match) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = idx_r;
          hit_data_nxt = slot_data_r[idx_r];
        end
        // keep the lowest free slot
        if (!valid_r[idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        if (last_slot) begin
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_RESP: begin
        if (commit) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = ST_NOT_FOUND;
          out_data_nxt.found_data = '0;
          case (req_r.cmd)
            CMD_FIND: begin
              if (hit_r) begin
                out_data_nxt.status     = ST_OK;
                out_data_nxt.found_data = hit_data_r;
              end
            end
            CMD_SAVE: begin
              if (hit_r) begin
                wr_data             = 1'b1;
                out_data_nxt.status = ST_OK;
              end else if (free_found_r) begin
                wr_key              = 1'b1;
                wr_data             = 1'b1;
                wr_idx              = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
                out_data_nxt.status = ST_OK;
              end else begin
                out_data_nxt.status = ST_FULL;
              end
            end
            CMD_DELETE: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                out_data_nxt.status  = ST_OK;
              end
            end
            default: begin
              out_data_nxt.status = ST_NOT_FOUND;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_data_r   <= hit_data_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    out_data_r   <= out_data_nxt;
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (wr_key) begin
      slot_disp_r[wr_idx] <= req_r.display_handle;
      slot_res_r[wr_idx]  <= req_r.resource_id;
      slot_ctx_r[wr_idx]  <= req_r.context_id;
    end
    if (wr_data) begin
      slot_data_r[wr_idx] <= req_r.write_data;
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_SCAN) && (idx_r == '0) && !hit_r && !free_found_r)
    else $error("transfer did not start a scan at slot zero");

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN || state_r == S_RESP) && hit_r) |-> valid_r[hit_idx_r])
    else $error("matched slot is not valid");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RESP) && !free_found_r) |-> (&valid_r))
    else $error("no free slot recorded while a slot is free");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result appeared without a commit");

  a_data_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.found_data != '0)) |-> (out_data_r.status == ST_OK))
    else $error("data returned with a failing status");

endmodule
